// ----- rtl/core/owbm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared widths, codes, register defaults and transaction layouts for the
// single-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

    localparam int COUNT_WIDTH   = 10;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int CFG_IDX_W     = 3;

    // Command codes carried in the op field
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_WAIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_RECOVER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH    = 3'd7;

    // Register reset values, in ticks
    localparam logic [COUNT_WIDTH-1:0] DEF_RESET_LOW    = COUNT_WIDTH'(70);
    localparam logic [COUNT_WIDTH-1:0] DEF_RESET_WAIT   = COUNT_WIDTH'(410);
    localparam logic [COUNT_WIDTH-1:0] DEF_SHORT_LOW    = COUNT_WIDTH'(6);
    localparam logic [COUNT_WIDTH-1:0] DEF_SAMPLE_DELAY = COUNT_WIDTH'(9);
    localparam logic [COUNT_WIDTH-1:0] DEF_READ_RECOVER = COUNT_WIDTH'(55);
    localparam logic [COUNT_WIDTH-1:0] DEF_ONE_HIGH     = COUNT_WIDTH'(64);
    localparam logic [COUNT_WIDTH-1:0] DEF_ZERO_LOW     = COUNT_WIDTH'(60);
    localparam logic [COUNT_WIDTH-1:0] DEF_ZERO_HIGH    = COUNT_WIDTH'(10);

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] reset_low_ticks;
        logic [COUNT_WIDTH-1:0] reset_wait_ticks;
        logic [COUNT_WIDTH-1:0] short_low_ticks;
        logic [COUNT_WIDTH-1:0] sample_delay_ticks;
        logic [COUNT_WIDTH-1:0] read_recover_ticks;
        logic [COUNT_WIDTH-1:0] one_high_ticks;
        logic [COUNT_WIDTH-1:0] zero_low_ticks;
        logic [COUNT_WIDTH-1:0] zero_high_ticks;
    } cfg_t;

    // Result of one tick; packed order here is MSB first
    typedef struct packed {
        logic                     rejected;
        logic [BITS_PER_BYTE-1:0] rx_byte;
        logic                     done_res;
        logic                     busy_res;
        logic                     drive_low;
    } res_t;

    localparam int IN_BITS   = 2 + BITS_PER_BYTE + 1;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int RES_BITS  = $bits(res_t);
    localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

endpackage

// ----- rtl/core/owbm_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_engine
// Slot sequencer: holds bus phase, tick counter, bit index and shift register,
// and works out the result of one tick from the current state and command.
// ----------------------------------------------------------------------------
module owbm_engine
    import owbm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step,
    input  op_t                      op,
    input  logic [BITS_PER_BYTE-1:0] tx_byte,
    input  logic                     line_in,
    input  cfg_t                     cfg,
    output res_t                     res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_SHORT_LOW,
        PH_SAMPLE_WAIT,
        PH_RECOVER,
        PH_ONE_HIGH,
        PH_ZERO_LOW,
        PH_ZERO_HIGH
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;
    logic [BIT_IDX_W-1:0]     bit_reg, bit_next;
    logic [BITS_PER_BYTE-1:0] shift_reg, shift_next;
    logic                     is_read_reg, is_read_next;

    always_comb begin
        logic [COUNT_WIDTH-1:0] len;
        logic                   last_bit;

        phase_next   = phase_reg;
        count_next   = count_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        is_read_next = is_read_reg;
        res          = '0;
        len          = '0;
        last_bit     = 1'b0;

        // Command start: the first phase runs on this same tick
        if (phase_reg != PH_IDLE) begin
            res.rejected = (op != OP_TICK);
        end else begin
            unique case (op)
                OP_RESET: begin
                    is_read_next = 1'b0;
                    bit_next     = '0;
                    shift_next   = '0;
                    phase_next   = PH_RST_LOW;
                    count_next   = '0;
                end
                OP_WRITE, OP_READ: begin
                    is_read_next = (op == OP_READ);
                    bit_next     = '0;
                    shift_next   = (op == OP_READ) ? '0 : tx_byte;
                    phase_next   = ((op == OP_READ) || tx_byte[0]) ? PH_SHORT_LOW
                                                                   : PH_ZERO_LOW;
                    count_next   = '0;
                end
                default: ;
            endcase
        end

        if (phase_next != PH_IDLE) begin
            unique case (phase_next)
                PH_RST_LOW:     len = cfg.reset_low_ticks;
                PH_RST_WAIT:    len = cfg.reset_wait_ticks;
                PH_SHORT_LOW:   len = cfg.short_low_ticks;
                PH_SAMPLE_WAIT: len = cfg.sample_delay_ticks;
                PH_RECOVER:     len = cfg.read_recover_ticks;
                PH_ONE_HIGH:    len = cfg.one_high_ticks;
                PH_ZERO_LOW:    len = cfg.zero_low_ticks;
                PH_ZERO_HIGH:   len = cfg.zero_high_ticks;
                default:        len = COUNT_WIDTH'(1);
            endcase
            if (len == '0) begin
                len = COUNT_WIDTH'(1);
            end
            res.busy_res  = 1'b1;
            res.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_SHORT_LOW)
                         || (phase_next == PH_ZERO_LOW);
            count_next    = count_next + COUNT_WIDTH'(1);
            last_bit      = (bit_next == BIT_IDX_W'(BITS_PER_BYTE - 1));

            if (count_next >= len) begin
                count_next = '0;
                unique case (phase_next)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT: begin
                        phase_next   = PH_IDLE;
                        res.done_res = 1'b1;
                    end
                    PH_SHORT_LOW: phase_next = is_read_next ? PH_SAMPLE_WAIT : PH_ONE_HIGH;
                    PH_SAMPLE_WAIT: begin
                        shift_next = {line_in, shift_next[BITS_PER_BYTE-1:1]};
                        phase_next = PH_RECOVER;
                    end
                    PH_ZERO_LOW: phase_next = PH_ZERO_HIGH;
                    PH_ONE_HIGH, PH_ZERO_HIGH: begin
                        shift_next = {1'b0, shift_next[BITS_PER_BYTE-1:1]};
                        if (last_bit) begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end else begin
                            bit_next   = bit_next + BIT_IDX_W'(1);
                            phase_next = shift_next[0] ? PH_SHORT_LOW : PH_ZERO_LOW;
                        end
                    end
                    PH_RECOVER: begin
                        if (last_bit) begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                            res.rx_byte  = shift_next;
                        end else begin
                            bit_next   = bit_next + BIT_IDX_W'(1);
                            phase_next = PH_SHORT_LOW;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            is_read_reg <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            is_read_reg <= is_read_next;
        end
    end

endmodule

// ----- rtl/core/one_wire_bus_master.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Tick-driven master for a single-wire open-drain bus: bus reset, byte write
// and byte read in timed slots with programmable durations.
// ----------------------------------------------------------------------------
// Each input transaction is one microsecond tick of bus time and may carry a
// command; each produces exactly one result transaction carrying the line
// drive for that tick, busy/done/rejected flags and the read byte on the
// done tick of a read. The block takes one tick per clock cycle: the slot
// sequencer updates its state on the accept edge and the result lands in a
// single output register, so a new tick is accepted every cycle while the
// output side keeps up, and also while a result is being handed over.
// Commands arriving while one runs are flagged by rejected and dropped. The
// user writes slot durations via cfg_* only while the bus is idle, which the
// block does not enforce; zero acts as one tick; bits travel LSB first.
// ----------------------------------------------------------------------------
module one_wire_bus_master
    import owbm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // Tick/command input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // [1:0] op, [9:2] tx_byte, [10] line_in

    // Result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // [0] drive_low, [1] busy_res,
                                              // [2] done_res, [10:3] rx_byte,
                                              // [11] rejected

    // Configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COUNT_WIDTH-1:0] cfg_wdata
);

    cfg_t  cfg_reg;
    res_t  res;
    logic  in_fire;
    logic  m_tvalid_reg;
    res_t  m_res_reg;

    // Accept whenever the output register is empty or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Timing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_ticks    <= DEF_RESET_LOW;
            cfg_reg.reset_wait_ticks   <= DEF_RESET_WAIT;
            cfg_reg.short_low_ticks    <= DEF_SHORT_LOW;
            cfg_reg.sample_delay_ticks <= DEF_SAMPLE_DELAY;
            cfg_reg.read_recover_ticks <= DEF_READ_RECOVER;
            cfg_reg.one_high_ticks     <= DEF_ONE_HIGH;
            cfg_reg.zero_low_ticks     <= DEF_ZERO_LOW;
            cfg_reg.zero_high_ticks    <= DEF_ZERO_HIGH;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RESET_LOW:    cfg_reg.reset_low_ticks    <= cfg_wdata;
                CFG_RESET_WAIT:   cfg_reg.reset_wait_ticks   <= cfg_wdata;
                CFG_SHORT_LOW:    cfg_reg.short_low_ticks    <= cfg_wdata;
                CFG_SAMPLE_DELAY: cfg_reg.sample_delay_ticks <= cfg_wdata;
                CFG_READ_RECOVER: cfg_reg.read_recover_ticks <= cfg_wdata;
                CFG_ONE_HIGH:     cfg_reg.one_high_ticks     <= cfg_wdata;
                CFG_ZERO_LOW:     cfg_reg.zero_low_ticks     <= cfg_wdata;
                CFG_ZERO_HIGH:    cfg_reg.zero_high_ticks    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Slot sequencer; advances only on an accepted tick
    owbm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_fire),
        .op      (op_t'(s_tdata[1:0])),
        .tx_byte (s_tdata[2 +: BITS_PER_BYTE]),
        .line_in (s_tdata[2 + BITS_PER_BYTE]),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Output register: load on accept, hold while stalled, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(m_res_reg);

endmodule
